// ===== design/layer_priority_pixel_composer_top_defines.svh =====
// Assertion macros shared by the composer RTL.
`ifndef LAYER_PRIORITY_PIXEL_COMPOSER_TOP_DEFINES_SVH
`define LAYER_PRIORITY_PIXEL_COMPOSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define LPPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define LPPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lppc_pkg.sv =====
package lppc_pkg;

    localparam int NUM_LAYERS  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int COLOUR_W    = 16;
    localparam int POS_W       = 8;
    localparam int PRIO_W      = 2;

    localparam logic [COLOUR_W-1:0] TRANSPARENT_COLOUR = 16'h8000;
    localparam logic [PRIO_W-1:0]   LOWEST_PRIORITY    = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DISPLAY_CONTROL     = 3'd0,
        REG_WINDOW0_BOUNDS      = 3'd1,
        REG_WINDOW1_BOUNDS      = 3'd2,
        REG_WINDOW_INSIDE_MASKS = 3'd3,
        REG_WINDOW_OUTSIDE_MASK = 3'd4,
        REG_LAYER_PRIORITIES    = 3'd5,
        REG_BACKDROP_COLOUR     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] display_control;
        logic [31:0] window0_bounds;
        logic [31:0] window1_bounds;
        logic [15:0] window_inside_masks;
        logic [3:0]  window_outside_mask;
        logic [7:0]  layer_priorities;
        logic [15:0] backdrop_colour;
    } lppc_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]    pixel_x;
        logic [POS_W-1:0]    line_y;
        logic [COLOUR_W-1:0] layer0_pixel;
        logic [COLOUR_W-1:0] layer1_pixel;
        logic [COLOUR_W-1:0] layer2_pixel;
        logic [COLOUR_W-1:0] layer3_pixel;
        logic [COLOUR_W-1:0] sprite_pixel;
        logic [PRIO_W-1:0]   sprite_priority;
    } lppc_in_t;

    typedef struct packed {
        logic [POS_W-1:0]    out_x;
        logic [POS_W-1:0]    out_y;
        logic [COLOUR_W-1:0] out_colour;
    } lppc_out_t;

endpackage

// ===== design/lppc_cfg_regs.sv =====
module lppc_cfg_regs
    import lppc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output lppc_cfg_t              cfg
);

    lppc_cfg_t cfg_reg;
    lppc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DISPLAY_CONTROL:     cfg_next.display_control     = wr_data[15:0];
                REG_WINDOW0_BOUNDS:      cfg_next.window0_bounds      = wr_data[31:0];
                REG_WINDOW1_BOUNDS:      cfg_next.window1_bounds      = wr_data[31:0];
                REG_WINDOW_INSIDE_MASKS: cfg_next.window_inside_masks = wr_data[15:0];
                REG_WINDOW_OUTSIDE_MASK: cfg_next.window_outside_mask = wr_data[3:0];
                REG_LAYER_PRIORITIES:    cfg_next.layer_priorities    = wr_data[7:0];
                REG_BACKDROP_COLOUR:     cfg_next.backdrop_colour     = wr_data[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/lppc_compose.sv =====
module lppc_compose
    import lppc_pkg::*;
(
    input  lppc_cfg_t cfg,
    input  lppc_in_t  pix,
    output lppc_out_t result
);

    // Bounds are x1 < x <= x2 and y1 < y <= y2, so an inverted window is empty.
    function automatic logic in_window(input logic [31:0] bounds,
                                       input logic [POS_W-1:0] x,
                                       input logic [POS_W-1:0] y);
        logic [7:0] x1;
        logic [7:0] x2;
        logic [7:0] y1;
        logic [7:0] y2;
        x1 = bounds[31:24];
        x2 = bounds[23:16];
        y1 = bounds[15:8];
        y2 = bounds[7:0];
        return (x > x1) && (x <= x2) && (y > y1) && (y <= y2);
    endfunction

    logic [NUM_LAYERS-1:0] enabled;
    logic                  win0_hit;
    logic                  win1_hit;
    logic [COLOUR_W-1:0]   layer_pix [NUM_LAYERS];
    logic [PRIO_W-1:0]     best;
    logic [COLOUR_W-1:0]   colour;

    assign layer_pix[0] = pix.layer0_pixel;
    assign layer_pix[1] = pix.layer1_pixel;
    assign layer_pix[2] = pix.layer2_pixel;
    assign layer_pix[3] = pix.layer3_pixel;

    assign win0_hit = cfg.display_control[13]
                      && in_window(cfg.window0_bounds, pix.pixel_x, pix.line_y);
    assign win1_hit = cfg.display_control[14]
                      && in_window(cfg.window1_bounds, pix.pixel_x, pix.line_y);

    always_comb
    begin
        enabled = cfg.display_control[11:8];
        if (|cfg.display_control[15:13])
        begin
            if (win0_hit)
                enabled = enabled & cfg.window_inside_masks[3:0];
            else if (win1_hit)
                enabled = enabled & cfg.window_inside_masks[11:8];
            else
                enabled = enabled & cfg.window_outside_mask;
        end
    end

    // Scanning from the top layer down with <= lets the lower index win a tie.
    always_comb
    begin
        best   = LOWEST_PRIORITY;
        colour = cfg.backdrop_colour;
        for (int i = NUM_LAYERS - 1; i >= 0; i--)
        begin
            if (enabled[i] && (layer_pix[i] != TRANSPARENT_COLOUR)
                && (cfg.layer_priorities[2*i +: 2] <= best))
            begin
                best   = cfg.layer_priorities[2*i +: 2];
                colour = layer_pix[i];
            end
        end
        if (cfg.display_control[12] && (pix.sprite_pixel != TRANSPARENT_COLOUR)
            && (pix.sprite_priority <= best))
        begin
            colour = pix.sprite_pixel;
        end
    end

    assign result.out_x      = pix.pixel_x;
    assign result.out_y      = pix.line_y;
    assign result.out_colour = colour;

endmodule

// ===== design/layer_priority_pixel_composer_top.sv =====
// Layer priority pixel composer.
// An accepted beat is held in the input register, then moves to the result register and out_valid.
// Throughput: one pixel per clock while out_stall is low, set by the input register feeding the result register.
// A stalled result holds while one more input beat is taken into the input register.
// Reset (rst_n low, asynchronous) empties both stages and clears the configuration to zero.
`include "layer_priority_pixel_composer_top_defines.svh"

module layer_priority_pixel_composer_top
    import lppc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lppc_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lppc_out_t              out_data
);

    lppc_cfg_t cfg;
    lppc_out_t composed;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    lppc_in_t  s1_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    lppc_out_t out_data_reg;

    logic      out_free;
    logic      in_take;

    lppc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    lppc_compose u_compose (
        .cfg    (cfg),
        .pix    (s1_data_reg),
        .result (composed)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
        if (out_free && s1_valid_reg)
            out_data_reg <= composed;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LPPC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg,
        "input stalled without a held beat in both stages")
    `LPPC_ASSERT_NEXT(a_take_fills_s1, in_take, s1_valid_reg,
        "accepted beat did not reach the input register")
    `LPPC_ASSERT_NEXT(a_s1_moves_out, s1_valid_reg && out_free, out_valid_reg,
        "input register beat did not move to the result register")
    `LPPC_ASSERT_NEXT(a_full_holds, in_stall, s1_valid_reg && out_valid_reg,
        "a stalled pipeline lost a beat")

endmodule
